### rtl/simt_pkg.sv
// ----------------------------------------------------------------------------
// simt_pkg
// Shared codes, field widths and types of the interval merge table.
// ----------------------------------------------------------------------------
package simt_pkg;

    localparam int FUNC_BITS   = 1;
    localparam int STATUS_BITS = 2;
    localparam int MEMBER_BITS = 16;

    typedef logic [FUNC_BITS-1:0]   t_func;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [MEMBER_BITS-1:0] t_member;

    localparam t_func FUNC_INSERT = 1'b0;
    localparam t_func FUNC_READ   = 1'b1;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_RANGE = 2'd2;

    localparam t_member MEMBER_MAX = '1;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic sum_lt_c;
        logic a_le_d;
    } t_alu_flags;

endpackage

### rtl/simt_req_if.sv
// ----------------------------------------------------------------------------
// simt_req_if
// Request channel: insert a block or read a table entry.
// ----------------------------------------------------------------------------
interface simt_req_if #(
    parameter int OFFSET_BITS = 48,
    parameter int SIZE_BITS   = 32,
    parameter int POS_BITS    = 6
);
    import simt_pkg::*;

    logic                   valid;
    logic                   ready;
    t_func                  func;
    logic [OFFSET_BITS-1:0] block_offset;
    logic [SIZE_BITS-1:0]   block_size;
    logic [POS_BITS-1:0]    entry_position;

    modport source (
        output valid, func, block_offset, block_size, entry_position,
        input  ready
    );

    modport sink (
        input  valid, func, block_offset, block_size, entry_position,
        output ready
    );

endinterface

### rtl/simt_rsp_if.sv
// ----------------------------------------------------------------------------
// simt_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface simt_rsp_if #(
    parameter int OFFSET_BITS = 48,
    parameter int POS_BITS    = 6,
    parameter int CNT_BITS    = 7
);
    import simt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] interval_start;
    logic [OFFSET_BITS:0]   interval_length;
    logic [POS_BITS-1:0]    interval_position;
    logic [CNT_BITS-1:0]    entry_total;
    t_member                member_count;
    t_status                status;

    modport source (
        output valid, interval_start, interval_length, interval_position,
               entry_total, member_count, status,
        input  ready
    );

    modport sink (
        input  valid, interval_start, interval_length, interval_position,
               entry_total, member_count, status,
        output ready
    );

endinterface

### rtl/simt_mem.sv
// ----------------------------------------------------------------------------
// simt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module simt_mem #(
    parameter  int DEPTH = 64,
    parameter  int WIDTH = 113,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/simt_alu.sv
// ----------------------------------------------------------------------------
// simt_alu
// Shared add/subtract unit with a compare on the sum and one on operand a.
// ----------------------------------------------------------------------------
module simt_alu #(
    parameter int W = 50
) (
    input  logic                 i_sub,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    input  logic [W-1:0]         i_c,
    input  logic [W-1:0]         i_d,
    output logic [W-1:0]         o_res,
    output simt_pkg::t_alu_flags o_flags
);
    import simt_pkg::*;

    always_comb begin
        o_res            = (i_sub == ALU_SUB) ? (i_a - i_b) : (i_a + i_b);
        o_flags.sum_lt_c = (o_res < i_c);
        o_flags.a_le_d   = (i_a <= i_d);
    end

endmodule

### rtl/simt_seq.sv
// ----------------------------------------------------------------------------
// simt_seq
// Sequencer: reads entries, or scans the sorted table, merges, shifts entries and writes back.
// ----------------------------------------------------------------------------
module simt_seq #(
    parameter  int MAX_ENTRIES = 64,
    parameter  int OFFSET_BITS = 48,
    parameter  int SIZE_BITS   = 32,
    localparam int POS_BITS    = $clog2(MAX_ENTRIES),
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1),
    localparam int LEN_BITS    = OFFSET_BITS + 1,
    localparam int END_BITS    = (OFFSET_BITS + 2 > SIZE_BITS + 1) ?
                                 OFFSET_BITS + 2 : SIZE_BITS + 1,
    localparam int ENTRY_BITS  = OFFSET_BITS + LEN_BITS + simt_pkg::MEMBER_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    simt_req_if.sink               i_req,
    output logic                   o_we,
    output logic [POS_BITS-1:0]    o_waddr,
    output logic [ENTRY_BITS-1:0]  o_wdata,
    output logic [POS_BITS-1:0]    o_raddr,
    input  logic [ENTRY_BITS-1:0]  i_rdata,
    output logic                   o_alu_sub,
    output logic [END_BITS-1:0]    o_alu_a,
    output logic [END_BITS-1:0]    o_alu_b,
    output logic [END_BITS-1:0]    o_alu_c,
    output logic [END_BITS-1:0]    o_alu_d,
    input  logic [END_BITS-1:0]    i_alu_res,
    input  simt_pkg::t_alu_flags   i_alu_flags,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output logic [OFFSET_BITS-1:0] o_res_start,
    output logic [LEN_BITS-1:0]    o_res_length,
    output logic [POS_BITS-1:0]    o_res_position,
    output logic [CNT_BITS-1:0]    o_res_total,
    output simt_pkg::t_member      o_res_member,
    output simt_pkg::t_status      o_res_status
);
    import simt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_NS   = 4'd2;
    localparam logic [3:0] S_NE   = 4'd3;
    localparam logic [3:0] S_LEN  = 4'd4;
    localparam logic [3:0] S_MOVE = 4'd5;
    localparam logic [3:0] S_PUT  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [CNT_BITS-1:0]    r_used, n_used;
    logic [OFFSET_BITS-1:0] r_s, n_s;
    logic [SIZE_BITS-1:0]   r_sz, n_sz;
    logic [END_BITS-1:0]    r_e, n_e;
    logic [POS_BITS-1:0]    r_idx, n_idx;
    logic [CNT_BITS-1:0]    r_i, n_i;
    logic [CNT_BITS-1:0]    r_k, n_k;
    t_member                r_mem, n_mem;
    logic [OFFSET_BITS-1:0] r_first_start, n_first_start;
    logic [END_BITS-1:0]    r_last_end, n_last_end;
    logic [OFFSET_BITS-1:0] r_ns, n_ns;
    logic [END_BITS-1:0]    r_ne, n_ne;
    logic [LEN_BITS-1:0]    r_len, n_len;
    logic [POS_BITS-1:0]    r_src, n_src;
    logic [POS_BITS-1:0]    r_dst, n_dst;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic                   r_down, n_down;
    logic [OFFSET_BITS-1:0] r_res_start, n_res_start;
    logic [LEN_BITS-1:0]    r_res_length, n_res_length;
    logic [POS_BITS-1:0]    r_res_position, n_res_position;
    logic [CNT_BITS-1:0]    r_res_total, n_res_total;
    t_member                r_res_member, n_res_member;
    t_status                r_res_status, n_res_status;

    logic [OFFSET_BITS-1:0] rd_start;
    logic [LEN_BITS-1:0]    rd_len;
    t_member                rd_member;
    logic [MEMBER_BITS:0]   mem_sum;
    t_member                mem_sat;
    logic [CNT_BITS-1:0]    idx_next;
    logic                   scan_last;

    assign rd_start  = i_rdata[ENTRY_BITS-1 -: OFFSET_BITS];
    assign rd_len    = i_rdata[MEMBER_BITS +: LEN_BITS];
    assign rd_member = i_rdata[MEMBER_BITS-1:0];
    assign mem_sum   = {1'b0, r_mem} + {1'b0, rd_member};
    assign mem_sat   = mem_sum[MEMBER_BITS] ? MEMBER_MAX : mem_sum[MEMBER_BITS-1:0];
    assign idx_next  = CNT_BITS'(r_idx) + CNT_BITS'(1);
    assign scan_last = (idx_next == r_used);

    always_comb begin
        n_state        = r_state;
        n_used         = r_used;
        n_s            = r_s;
        n_sz           = r_sz;
        n_e            = r_e;
        n_idx          = r_idx;
        n_i            = r_i;
        n_k            = r_k;
        n_mem          = r_mem;
        n_first_start  = r_first_start;
        n_last_end     = r_last_end;
        n_ns           = r_ns;
        n_ne           = r_ne;
        n_len          = r_len;
        n_src          = r_src;
        n_dst          = r_dst;
        n_cnt          = r_cnt;
        n_down         = r_down;
        n_res_start    = r_res_start;
        n_res_length   = r_res_length;
        n_res_position = r_res_position;
        n_res_total    = r_res_total;
        n_res_member   = r_res_member;
        n_res_status   = r_res_status;
        o_we           = 1'b0;
        o_waddr        = r_dst;
        o_wdata        = i_rdata;
        o_raddr        = r_src;
        o_alu_sub      = ALU_ADD;
        o_alu_a        = '0;
        o_alu_b        = '0;
        o_alu_c        = '0;
        o_alu_d        = '0;
        i_req.ready    = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                o_alu_a = END_BITS'(i_req.block_offset);
                o_alu_b = END_BITS'(i_req.block_size);
                o_raddr = (i_req.func == FUNC_READ) ? i_req.entry_position : '0;
                if (i_req.valid) begin
                    n_s   = i_req.block_offset;
                    n_sz  = i_req.block_size;
                    n_e   = i_alu_res;
                    n_idx = '0;
                    n_i   = '0;
                    n_k   = '0;
                    n_mem = MEMBER_BITS'(1);
                    if (i_req.func == FUNC_READ) begin
                        n_idx = i_req.entry_position;
                        if (CNT_BITS'(i_req.entry_position) < r_used) begin
                            n_state = S_RD;
                        end else begin
                            n_res_start    = '0;
                            n_res_length   = '0;
                            n_res_position = '0;
                            n_res_total    = r_used;
                            n_res_member   = '0;
                            n_res_status   = STATUS_RANGE;
                            n_state        = S_OUT;
                        end
                    end else begin
                        n_state = (r_used == '0) ? S_NS : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_alu_a = END_BITS'(rd_start);
                o_alu_b = END_BITS'(rd_len);
                o_alu_c = END_BITS'(r_s);
                o_alu_d = r_e;
                o_raddr = POS_BITS'(idx_next);
                n_idx   = POS_BITS'(idx_next);
                if (i_alu_flags.sum_lt_c) begin
                    n_i = idx_next;
                    if (scan_last) begin
                        n_state = S_NS;
                    end
                end else if (i_alu_flags.a_le_d) begin
                    if (r_k == '0) begin
                        n_first_start = rd_start;
                    end
                    n_last_end = i_alu_res;
                    n_k        = r_k + CNT_BITS'(1);
                    n_mem      = mem_sat;
                    if (scan_last) begin
                        n_state = S_NS;
                    end
                end else begin
                    n_state = S_NS;
                end
            end
            S_NS: begin
                o_alu_a = END_BITS'(r_first_start);
                o_alu_c = END_BITS'(r_s);
                n_ns    = ((r_k != '0) && i_alu_flags.sum_lt_c) ? r_first_start : r_s;
                n_state = S_NE;
                if ((r_k == '0) && (r_used == CNT_BITS'(MAX_ENTRIES))) begin
                    n_res_start    = r_s;
                    n_res_length   = LEN_BITS'(r_sz);
                    n_res_position = POS_BITS'(r_i);
                    n_res_total    = r_used;
                    n_res_member   = '0;
                    n_res_status   = STATUS_FULL;
                    n_state        = S_OUT;
                end
            end
            S_NE: begin
                o_alu_a = r_last_end;
                o_alu_d = r_e;
                n_ne    = ((r_k != '0) && !i_alu_flags.a_le_d) ? r_last_end : r_e;
                if (r_k == '0) begin
                    n_down = 1'b1;
                    n_src  = POS_BITS'(r_used - CNT_BITS'(1));
                    n_dst  = POS_BITS'(r_used);
                    n_cnt  = r_used - r_i;
                end else begin
                    n_down = 1'b0;
                    n_src  = POS_BITS'(r_i + r_k);
                    n_dst  = POS_BITS'(r_i + CNT_BITS'(1));
                    n_cnt  = (r_k == CNT_BITS'(1)) ? '0 : (r_used - r_i - r_k);
                end
                n_state = S_LEN;
            end
            S_LEN: begin
                o_alu_sub = ALU_SUB;
                o_alu_a   = r_ne;
                o_alu_b   = END_BITS'(r_ns);
                n_len     = i_alu_res[LEN_BITS-1:0];
                o_raddr   = r_src;
                n_src     = r_down ? (r_src - POS_BITS'(1)) : (r_src + POS_BITS'(1));
                n_state   = (r_cnt == '0) ? S_PUT : S_MOVE;
            end
            S_MOVE: begin
                o_raddr = r_src;
                n_src   = r_down ? (r_src - POS_BITS'(1)) : (r_src + POS_BITS'(1));
                o_we    = 1'b1;
                o_waddr = r_dst;
                o_wdata = i_rdata;
                n_dst   = r_down ? (r_dst - POS_BITS'(1)) : (r_dst + POS_BITS'(1));
                n_cnt   = r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_we           = 1'b1;
                o_waddr        = POS_BITS'(r_i);
                o_wdata        = {r_ns, r_len, r_mem};
                n_used         = r_used - r_k + CNT_BITS'(1);
                n_res_start    = r_ns;
                n_res_length   = r_len;
                n_res_position = POS_BITS'(r_i);
                n_res_total    = r_used - r_k + CNT_BITS'(1);
                n_res_member   = r_mem;
                n_res_status   = STATUS_OK;
                n_state        = S_OUT;
            end
            S_RD: begin
                n_res_start    = rd_start;
                n_res_length   = rd_len;
                n_res_position = r_idx;
                n_res_total    = r_used;
                n_res_member   = rd_member;
                n_res_status   = STATUS_OK;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s            <= n_s;
        r_sz           <= n_sz;
        r_e            <= n_e;
        r_idx          <= n_idx;
        r_i            <= n_i;
        r_k            <= n_k;
        r_mem          <= n_mem;
        r_first_start  <= n_first_start;
        r_last_end     <= n_last_end;
        r_ns           <= n_ns;
        r_ne           <= n_ne;
        r_len          <= n_len;
        r_src          <= n_src;
        r_dst          <= n_dst;
        r_cnt          <= n_cnt;
        r_down         <= n_down;
        r_res_start    <= n_res_start;
        r_res_length   <= n_res_length;
        r_res_position <= n_res_position;
        r_res_total    <= n_res_total;
        r_res_member   <= n_res_member;
        r_res_status   <= n_res_status;
    end

    assign o_res_valid    = (r_state == S_OUT);
    assign o_res_start    = r_res_start;
    assign o_res_length   = r_res_length;
    assign o_res_position = r_res_position;
    assign o_res_total    = r_res_total;
    assign o_res_member   = r_res_member;
    assign o_res_status   = r_res_status;

endmodule

### rtl/sorted_interval_merge_table.sv
// ----------------------------------------------------------------------------
// sorted_interval_merge_table
// Sorted table of disjoint intervals; inserts merge touching intervals.
// Insert: scans up to the first entry past the block, forms the new start, end and
// length, moves entries to open or close a gap and writes the merged entry; a full
// table with nothing to merge reports full after the scan. Entries scanned plus
// moved are at most MAX_ENTRIES + 1. Reads return the entry or a range status.
// The next request is taken as the result is presented, even while it waits.
// Reset clears the entry count; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_interval_merge_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int OFFSET_BITS = 48,
    parameter int SIZE_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    simt_req_if.sink   i_req,
    simt_rsp_if.source o_rsp
);
    import simt_pkg::*;

    localparam int POS_BITS   = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_BITS   = OFFSET_BITS + 1;
    localparam int END_BITS   = (OFFSET_BITS + 2 > SIZE_BITS + 1) ?
                                OFFSET_BITS + 2 : SIZE_BITS + 1;
    localparam int ENTRY_BITS = OFFSET_BITS + LEN_BITS + MEMBER_BITS;

    logic                   mem_we;
    logic [POS_BITS-1:0]    mem_waddr;
    logic [ENTRY_BITS-1:0]  mem_wdata;
    logic [POS_BITS-1:0]    mem_raddr;
    logic [ENTRY_BITS-1:0]  mem_rdata;
    logic                   alu_sub;
    logic [END_BITS-1:0]    alu_a;
    logic [END_BITS-1:0]    alu_b;
    logic [END_BITS-1:0]    alu_c;
    logic [END_BITS-1:0]    alu_d;
    logic [END_BITS-1:0]    alu_res;
    t_alu_flags             alu_flags;
    logic                   res_valid;
    logic                   res_ready;
    logic [OFFSET_BITS-1:0] res_start;
    logic [LEN_BITS-1:0]    res_length;
    logic [POS_BITS-1:0]    res_position;
    logic [CNT_BITS-1:0]    res_total;
    t_member                res_member;
    t_status                res_status;

    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_out_start;
    logic [LEN_BITS-1:0]    r_out_length;
    logic [POS_BITS-1:0]    r_out_position;
    logic [CNT_BITS-1:0]    r_out_total;
    t_member                r_out_member;
    t_status                r_out_status;

    simt_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENTRY_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    simt_alu #(
        .W (END_BITS)
    ) u_alu (
        .i_sub   (alu_sub),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_c     (alu_c),
        .i_d     (alu_d),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    simt_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .o_we           (mem_we),
        .o_waddr        (mem_waddr),
        .o_wdata        (mem_wdata),
        .o_raddr        (mem_raddr),
        .i_rdata        (mem_rdata),
        .o_alu_sub      (alu_sub),
        .o_alu_a        (alu_a),
        .o_alu_b        (alu_b),
        .o_alu_c        (alu_c),
        .o_alu_d        (alu_d),
        .i_alu_res      (alu_res),
        .i_alu_flags    (alu_flags),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res_start    (res_start),
        .o_res_length   (res_length),
        .o_res_position (res_position),
        .o_res_total    (res_total),
        .o_res_member   (res_member),
        .o_res_status   (res_status)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_start    <= res_start;
            r_out_length   <= res_length;
            r_out_position <= res_position;
            r_out_total    <= res_total;
            r_out_member   <= res_member;
            r_out_status   <= res_status;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.interval_start    = r_out_start;
    assign o_rsp.interval_length   = r_out_length;
    assign o_rsp.interval_position = r_out_position;
    assign o_rsp.entry_total       = r_out_total;
    assign o_rsp.member_count      = r_out_member;
    assign o_rsp.status            = r_out_status;

endmodule

### rtl/simt_chk.sv
// ----------------------------------------------------------------------------
// simt_chk
// Port checks on the result channel of the interval merge table.
// ----------------------------------------------------------------------------
module simt_chk #(
    parameter  int MAX_ENTRIES = 64,
    localparam int POS_BITS    = $clog2(MAX_ENTRIES),
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1)
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [POS_BITS-1:0] i_position,
    input logic [CNT_BITS-1:0] i_total,
    input simt_pkg::t_member   i_member,
    input simt_pkg::t_status   i_status,
    input logic                i_start_zero
);
    import simt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_total))
        else $error("result item dropped or changed while stalled");

    a_ok_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STATUS_OK) |->
            (CNT_BITS'(i_position) < i_total))
        else $error("ok result position not below entry total");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STATUS_FULL) |->
            (i_total == CNT_BITS'(MAX_ENTRIES)) && (i_member == '0))
        else $error("table full reported with table not full");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STATUS_RANGE) |->
            i_start_zero && (i_member == '0) && (i_position == '0))
        else $error("out of range read carries nonzero fields");

endmodule

bind sorted_interval_merge_table simt_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_simt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_position   (o_rsp.interval_position),
    .i_total      (o_rsp.entry_total),
    .i_member     (o_rsp.member_count),
    .i_status     (o_rsp.status),
    .i_start_zero (o_rsp.interval_start == '0)
);

### sim/simt_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// simt_table_checker
// Watches the request and response channels of the interval merge table,
// keeps its own sorted interval table, predicts each result item and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module simt_table_checker #(
    parameter int MAX_ENTRIES = 64,
    parameter int OFFSET_BITS = 48,
    parameter int SIZE_BITS   = 32,
    parameter int POS_BITS    = 6,
    parameter int CNT_BITS    = 7
) (
    input  logic i_clk,
    input  logic i_rst_n,
    simt_req_if  i_req,
    simt_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending_count,
    output int   o_checked_count
);
    import simt_pkg::*;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS:0]   length;
        logic [POS_BITS-1:0]    position;
        logic [CNT_BITS-1:0]    total;
        t_member                members;
        t_status                status;
    } t_interval_result;

    logic [OFFSET_BITS-1:0] tbl_start   [MAX_ENTRIES];
    logic [OFFSET_BITS:0]   tbl_length  [MAX_ENTRIES];
    t_member                tbl_members [MAX_ENTRIES];
    int                     entries_used;

    t_interval_result pending_intervals[$];
    t_interval_result predicted;
    int               fail_total;
    int               checked_total;

    function automatic logic [63:0] entry_end(input int idx);
        return 64'(tbl_start[idx]) + 64'(tbl_length[idx]);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 checked_total, field, got, want);
        fail_total++;
    endtask

    task automatic look_up_entry(input logic [POS_BITS-1:0] pos,
                                 output t_interval_result res);
        res = '0;
        res.total = CNT_BITS'(entries_used);
        if (int'(pos) < entries_used) begin
            res.start    = tbl_start[pos];
            res.length   = tbl_length[pos];
            res.position = pos;
            res.members  = tbl_members[pos];
            res.status   = STATUS_OK;
        end else begin
            res.status = STATUS_RANGE;
        end
    endtask

    task automatic merge_block(input logic [OFFSET_BITS-1:0] blk_start,
                               input logic [SIZE_BITS-1:0] blk_size,
                               output t_interval_result res);
        logic [63:0] blk_end;
        logic [63:0] new_lo;
        logic [63:0] new_hi;
        int          first;
        int          last;
        int          absorbed;
        int          new_used;
        int          mem;
        res = '0;
        blk_end = 64'(blk_start) + 64'(blk_size);
        first = 0;
        while (first < entries_used && entry_end(first) < 64'(blk_start)) first++;
        last = first;
        while (last < entries_used && 64'(tbl_start[last]) <= blk_end) last++;
        absorbed = last - first;
        if (absorbed == 0 && entries_used >= MAX_ENTRIES) begin
            res.start    = blk_start;
            res.length   = (OFFSET_BITS+1)'(blk_size);
            res.position = POS_BITS'(first);
            res.total    = CNT_BITS'(entries_used);
            res.members  = '0;
            res.status   = STATUS_FULL;
        end else begin
            new_lo = 64'(blk_start);
            new_hi = blk_end;
            mem = 1;
            for (int m = first; m < last; m++) begin
                if (64'(tbl_start[m]) < new_lo) new_lo = 64'(tbl_start[m]);
                if (entry_end(m) > new_hi) new_hi = entry_end(m);
                mem += int'(tbl_members[m]);
                if (mem > int'(MEMBER_MAX)) mem = int'(MEMBER_MAX);
            end
            new_used = entries_used - absorbed + 1;
            // open a slot for a new interval, or close the hole left by absorbed ones
            if (absorbed == 0) begin
                for (int m = entries_used; m > first; m--) begin
                    tbl_start[m]   = tbl_start[m-1];
                    tbl_length[m]  = tbl_length[m-1];
                    tbl_members[m] = tbl_members[m-1];
                end
            end else if (absorbed > 1) begin
                for (int m = first + 1; m < new_used; m++) begin
                    tbl_start[m]   = tbl_start[m+absorbed-1];
                    tbl_length[m]  = tbl_length[m+absorbed-1];
                    tbl_members[m] = tbl_members[m+absorbed-1];
                end
            end
            tbl_start[first]   = new_lo[OFFSET_BITS-1:0];
            tbl_length[first]  = (OFFSET_BITS+1)'(new_hi - new_lo);
            tbl_members[first] = t_member'(mem);
            entries_used = new_used;
            res.start    = tbl_start[first];
            res.length   = tbl_length[first];
            res.position = POS_BITS'(first);
            res.total    = CNT_BITS'(new_used);
            res.members  = tbl_members[first];
            res.status   = STATUS_OK;
        end
    endtask

    task automatic check_result();
        t_interval_result want;
        if (pending_intervals.size() == 0) begin
            report_mismatch("result with no item pending", 64'(i_rsp.interval_start),
                            64'(0));
        end else begin
            want = pending_intervals.pop_front();
            if (i_rsp.interval_start !== want.start)
                report_mismatch("interval_start", 64'(i_rsp.interval_start),
                                64'(want.start));
            if (i_rsp.interval_length !== want.length)
                report_mismatch("interval_length", 64'(i_rsp.interval_length),
                                64'(want.length));
            if (i_rsp.interval_position !== want.position)
                report_mismatch("interval_position", 64'(i_rsp.interval_position),
                                64'(want.position));
            if (i_rsp.entry_total !== want.total)
                report_mismatch("entry_total", 64'(i_rsp.entry_total), 64'(want.total));
            if (i_rsp.member_count !== want.members)
                report_mismatch("member_count", 64'(i_rsp.member_count),
                                64'(want.members));
            if (i_rsp.status !== want.status)
                report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
        end
        checked_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries_used = 0;
            pending_intervals.delete();
            fail_total = 0;
            checked_total = 0;
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) check_result();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                if (i_req.func == FUNC_READ)
                    look_up_entry(i_req.entry_position, predicted);
                else
                    merge_block(i_req.block_offset, i_req.block_size, predicted);
                pending_intervals.push_back(predicted);
            end
        end
        o_fail_count    <= fail_total;
        o_pending_count <= pending_intervals.size();
        o_checked_count <= checked_total;
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the interval merge table testbench. Drives inserts and reads with
// bursty request timing and a stalling response side; a checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
    import simt_pkg::*;

    localparam int  MAX_ENTRIES  = 64;
    localparam int  OFFSET_BITS  = 48;
    localparam int  SIZE_BITS    = 32;
    localparam int  CLK_PERIOD   = 10;
    localparam int  RESET_CYCLES = 7;
    localparam int  ITEM_TARGET  = 550;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  CYCLE_LIMIT  = 1000000;

    localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;
    localparam logic [SIZE_BITS-1:0]   SIZE_TOP   = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int burst_left  = 0;
    int inserts_sent = 0;
    int reads_sent   = 0;
    int episodes     = 0;
    int stall_mode   = 0;
    logic [7:0] stall_mask = 8'hFF;

    simt_req_if req_ch();
    simt_rsp_if rsp_ch();

    sorted_interval_merge_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .SIZE_BITS   (SIZE_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    simt_table_checker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d results outstanding", pending_count);
            $display("status: fail");
            $finish;
        end
    end

    // response side: pick a stall pattern: always ready, random, or a repeating mask
    always @(negedge i_clk) begin
        if (cycle_count % 256 == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_mask <= 8'($urandom) | 8'h01;
        end
        case (stall_mode)
            0: begin
                rsp_ch.ready <= 1'b1;
            end
            1: begin
                rsp_ch.ready <= 1'($urandom);
            end
            default: begin
                rsp_ch.ready <= stall_mask[3'(cycle_count)];
            end
        endcase
    end

    function automatic logic [OFFSET_BITS-1:0] random_offset();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_request(input t_func f, input logic [OFFSET_BITS-1:0] off,
                                input logic [SIZE_BITS-1:0] sz, input logic [5:0] pos);
        int gap;
        @(negedge i_clk);
        req_ch.valid          <= 1'b1;
        req_ch.func           <= f;
        req_ch.block_offset   <= off;
        req_ch.block_size     <= sz;
        req_ch.entry_position <= pos;
        do begin
            @(posedge i_clk);
        end while (req_ch.ready !== 1'b1);
        if (f == FUNC_READ) reads_sent++;
        else inserts_sent++;
        // close the burst with a random gap, sometimes none
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic insert_block(input logic [OFFSET_BITS-1:0] off,
                                input logic [SIZE_BITS-1:0] sz);
        send_request(FUNC_INSERT, off, sz, 6'($urandom));
    endtask

    task automatic read_entry(input logic [5:0] pos);
        send_request(FUNC_READ, random_offset(), SIZE_TOP & $urandom, pos);
    endtask

    task automatic run_episode();
        logic [OFFSET_BITS-1:0] base;
        logic [SIZE_BITS-1:0]   stride;
        logic [SIZE_BITS-1:0]   sz;
        int                     slots;
        int                     count;
        int                     pick;
        base   = {16'($urandom_range(0, 16'hFFFE)), 32'($urandom)};
        stride = $urandom_range(4, 1 << 20);
        slots  = $urandom_range(72, 96);
        count  = $urandom_range(80, 130);
        if (count > ITEM_TARGET - 1 - inserts_sent - reads_sent)
            count = ITEM_TARGET - 1 - inserts_sent - reads_sent;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                read_entry(6'($urandom));
            end else if (pick < 22) begin
                insert_block(random_offset(), SIZE_TOP & $urandom);
            end else if (pick < 24) begin
                insert_block(base + ($urandom % (slots * stride)), SIZE_TOP & $urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0:       sz = '0;
                    1:       sz = stride;
                    2:       sz = stride * $urandom_range(2, 4);
                    default: sz = $urandom_range(0, stride - 2);
                endcase
                insert_block(base + $urandom_range(0, slots - 1) * stride, sz);
            end
        end
        // fold the whole window back into one interval
        insert_block(base, (slots + 4) * stride);
        episodes++;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.func           = FUNC_INSERT;
        req_ch.block_offset   = '0;
        req_ch.block_size     = '0;
        req_ch.entry_position = '0;
        rsp_ch.ready          = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        read_entry(6'd0);
        read_entry(6'd63);
        insert_block('0, '0);
        insert_block(OFFSET_TOP, SIZE_TOP);
        insert_block('0, '0);
        insert_block(48'd100, 32'd50);
        insert_block(48'd150, 32'd0);
        insert_block(48'd200, 32'd10);
        insert_block(48'd300, 32'd10);
        insert_block(48'd90, 32'd250);
        insert_block(48'd50, 32'd40);
        insert_block(48'd1000, 32'd5);
        insert_block(48'd20, 32'd5);
        insert_block(OFFSET_TOP - 1, '0);
        insert_block(OFFSET_TOP - 5, 32'd5);
        for (int p = 0; p < 7; p++) read_entry(6'(p));
        read_entry(6'd63);

        while (inserts_sent + reads_sent < ITEM_TARGET) run_episode();

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d inserts and %0d reads across %0d address windows",
                 inserts_sent, reads_sent, episodes);
        $display("checked %0d results, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
